[sv/ems_pkg.sv]
// ----------------------------------------------------------------------------
// Move sequencer package
// Shared types, register indexes and codes for the encoder move sequencer.
// ----------------------------------------------------------------------------
package ems_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_LEFT_TRIM      = 3'd0;
    localparam logic [2:0] CFG_RIGHT_TRIM     = 3'd1;
    localparam logic [2:0] CFG_MAX_SPEED      = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT_MS     = 3'd3;
    localparam logic [2:0] CFG_OBSTACLE_MODE  = 3'd4;
    localparam logic [2:0] CFG_OBSTACLE_THR   = 3'd5;
    localparam logic [2:0] CFG_PAUSE_MS       = 3'd6;
    localparam logic [2:0] CFG_COOLDOWN_MS    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Direction codes
    localparam logic [1:0] DIR_FORWARD  = 2'd0;
    localparam logic [1:0] DIR_BACKWARD = 2'd1;
    localparam logic [1:0] DIR_RIGHT    = 2'd2;
    localparam logic [1:0] DIR_LEFT     = 2'd3;

    // Obstacle modes (the unused code behaves as ignore)
    localparam logic [1:0] OBS_IGNORE = 2'd0;
    localparam logic [1:0] OBS_STOP   = 2'd1;
    localparam logic [1:0] OBS_PAUSE  = 2'd2;

    // Reset values of the registers
    localparam logic [15:0] RST_LEFT_TRIM    = 16'd16384;
    localparam logic [15:0] RST_RIGHT_TRIM   = 16'd16384;
    localparam logic [14:0] RST_MAX_SPEED    = 15'd32767;
    localparam logic [19:0] RST_TIMEOUT_MS   = 20'd30000;
    localparam logic [1:0]  RST_OBS_MODE     = OBS_IGNORE;
    localparam logic [11:0] RST_OBS_THR      = 12'd200;
    localparam logic [15:0] RST_PAUSE_MS     = 16'd3000;
    localparam logic [15:0] RST_COOLDOWN_MS  = 16'd2000;

    // Q2.14 rounding constant and run counter ceiling
    localparam logic [31:0] TRIM_ROUND = 32'd8192;
    localparam int          TRIM_SHIFT = 14;
    localparam logic [19:0] RUN_MAX    = 20'hFFFFF;

    typedef struct packed {
        logic [15:0] left_trim;
        logic [15:0] right_trim;
        logic [14:0] max_speed;
        logic [19:0] timeout_ms;
        logic [1:0]  obstacle_mode;
        logic [11:0] obstacle_threshold;
        logic [15:0] pause_ms;
        logic [15:0] cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic               cmd;
        logic [1:0]         direction;
        logic [14:0]        speed;
        logic [23:0]        target_counts;
        logic signed [31:0] right_count;
        logic signed [31:0] left_count;
        logic [11:0]        obstacle_dist;
    } t_item;

    typedef struct packed {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic               moving;
        logic               paused;
        logic               done_res;
        logic               timed_out;
    } t_res;

endpackage

[sv/ems_in_if.sv]
// ----------------------------------------------------------------------------
// Move sequencer input channel
// Valid/ready channel carrying start and tick transactions.
// ----------------------------------------------------------------------------
interface ems_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [1:0]         direction;
    logic [14:0]        speed;
    logic [23:0]        target_counts;
    logic signed [31:0] right_count;
    logic signed [31:0] left_count;
    logic [11:0]        obstacle_dist;

    modport source (
        output valid, cmd, direction, speed, target_counts,
               right_count, left_count, obstacle_dist,
        input  ready
    );

    modport sink (
        input  valid, cmd, direction, speed, target_counts,
               right_count, left_count, obstacle_dist,
        output ready
    );
endinterface

[sv/ems_out_if.sv]
// ----------------------------------------------------------------------------
// Move sequencer result channel
// Valid/ready channel carrying one result transaction per input.
// ----------------------------------------------------------------------------
interface ems_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               moving;
    logic               paused;
    logic               done_res;
    logic               timed_out;

    modport source (
        output valid, left_drive, right_drive, moving, paused, done_res, timed_out,
        input  ready
    );

    modport sink (
        input  valid, left_drive, right_drive, moving, paused, done_res, timed_out,
        output ready
    );
endinterface

[sv/encoder_move_sequencer.sv]
// ----------------------------------------------------------------------------
// Encoder move sequencer
// Differential-drive move control with obstacle pause and move timeout.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries start transactions (cmd = start: direction, speed, target)
//   and tick transactions (cmd = tick: one per millisecond, with both encoder
//   counts and the obstacle distance). o_res returns exactly one result
//   transaction per input transaction, in order: the two wheel drives and the
//   moving, paused, done and timed-out flags.
//   Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_data, one register
//   per write, only while no transaction is in flight.
// Flow:
//   A transaction lands in the input register, is evaluated in one pass of
//   combinational logic (trim multiply on start, count compare on tick) and
//   lands in the result register.
//   One transaction per cycle is sustained while o_res is not stalled.
// Reset:
//   Synchronous, active low. Both stages empty, no move active, cooldown and
//   pause cleared, obstacle pause armed, registers at their default values.
// Stall:
//   While o_res is stalled the result register holds; the input register can
//   still take one more transaction, after which i_in.ready drops.
// ----------------------------------------------------------------------------
module encoder_move_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    ems_in_if.sink                              i_in,
    ems_out_if.source                           o_res,
    input  logic                                i_cfg_we,
    input  logic [ems_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ems_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    ems_pkg::t_cfg  r_cfg;
    ems_pkg::t_item r_in;
    ems_pkg::t_res  r_out;
    ems_pkg::t_res  res;
    logic           r_in_valid;
    logic           r_out_valid;
    logic           advance;
    logic           accept;
    logic           obs_wr;

    // Move the held transaction forward whenever the result slot is free
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign accept      = i_in.valid && i_in.ready;
    assign obs_wr      = i_cfg_we && (i_cfg_idx >= ems_pkg::CFG_OBSTACLE_MODE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_trim          <= ems_pkg::RST_LEFT_TRIM;
            r_cfg.right_trim         <= ems_pkg::RST_RIGHT_TRIM;
            r_cfg.max_speed          <= ems_pkg::RST_MAX_SPEED;
            r_cfg.timeout_ms         <= ems_pkg::RST_TIMEOUT_MS;
            r_cfg.obstacle_mode      <= ems_pkg::RST_OBS_MODE;
            r_cfg.obstacle_threshold <= ems_pkg::RST_OBS_THR;
            r_cfg.pause_ms           <= ems_pkg::RST_PAUSE_MS;
            r_cfg.cooldown_ms        <= ems_pkg::RST_COOLDOWN_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ems_pkg::CFG_LEFT_TRIM:     r_cfg.left_trim          <= i_cfg_data[15:0];
                ems_pkg::CFG_RIGHT_TRIM:    r_cfg.right_trim         <= i_cfg_data[15:0];
                ems_pkg::CFG_MAX_SPEED:     r_cfg.max_speed          <= i_cfg_data[14:0];
                ems_pkg::CFG_TIMEOUT_MS:    r_cfg.timeout_ms         <= i_cfg_data[19:0];
                ems_pkg::CFG_OBSTACLE_MODE: r_cfg.obstacle_mode      <= i_cfg_data[1:0];
                ems_pkg::CFG_OBSTACLE_THR:  r_cfg.obstacle_threshold <= i_cfg_data[11:0];
                ems_pkg::CFG_PAUSE_MS:      r_cfg.pause_ms           <= i_cfg_data[15:0];
                ems_pkg::CFG_COOLDOWN_MS:   r_cfg.cooldown_ms        <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: hold the transaction until it can be evaluated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.cmd           <= i_in.cmd;
            r_in.direction     <= i_in.direction;
            r_in.speed         <= i_in.speed;
            r_in.target_counts <= i_in.target_counts;
            r_in.right_count   <= i_in.right_count;
            r_in.left_count    <= i_in.left_count;
            r_in.obstacle_dist <= i_in.obstacle_dist;
        end
    end

    ems_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_obs_wr (obs_wr),
        .o_res    (res)
    );

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.left_drive  = r_out.left_drive;
    assign o_res.right_drive = r_out.right_drive;
    assign o_res.moving      = r_out.moving;
    assign o_res.paused      = r_out.paused;
    assign o_res.done_res    = r_out.done_res;
    assign o_res.timed_out   = r_out.timed_out;
endmodule

[sv/ems_trim.sv]
// ----------------------------------------------------------------------------
// Wheel trim
// Scale a speed magnitude by a Q2.14 gain, round, limit and apply the sign.
// ----------------------------------------------------------------------------
module ems_trim (
    input  logic [14:0]        i_mag,
    input  logic               i_neg,
    input  logic [15:0]        i_trim,
    input  logic [14:0]        i_max,
    output logic signed [15:0] o_drive
);
    logic [31:0] sum;
    logic [17:0] scaled;
    logic [14:0] lim;

    // Product fits in 31 bits, so the rounded sum never wraps
    assign sum    = 32'(i_mag) * 32'(i_trim) + ems_pkg::TRIM_ROUND;
    assign scaled = sum[31:ems_pkg::TRIM_SHIFT];
    assign lim    = (scaled > 18'(i_max)) ? i_max : scaled[14:0];
    assign o_drive = i_neg ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
endmodule

[sv/ems_delta.sv]
// ----------------------------------------------------------------------------
// Wheel travel check
// Magnitude of the wrapped count difference compared against the target.
// ----------------------------------------------------------------------------
module ems_delta (
    input  logic [31:0] i_cur,
    input  logic [31:0] i_start,
    input  logic [23:0] i_target,
    output logic        o_reached
);
    logic [31:0] diff;
    logic [31:0] mag;

    assign diff      = i_cur - i_start;
    assign mag       = diff[31] ? (32'd0 - diff) : diff;
    assign o_reached = mag >= 32'(i_target);
endmodule

[sv/ems_ctrl.sv]
// ----------------------------------------------------------------------------
// Move sequencer control
// Move state, obstacle handling and per-transaction result decision.
// ----------------------------------------------------------------------------
module ems_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  ems_pkg::t_item i_item,
    input  ems_pkg::t_cfg  i_cfg,
    input  logic           i_obs_wr,
    output ems_pkg::t_res  o_res
);
    logic               r_active, n_active;
    logic [31:0]        r_start_r, n_start_r;
    logic [31:0]        r_start_l, n_start_l;
    logic [23:0]        r_target, n_target;
    logic [19:0]        r_run, n_run;
    logic signed [15:0] r_cmd_l, n_cmd_l;
    logic signed [15:0] r_cmd_r, n_cmd_r;
    logic [15:0]        r_pause, n_pause;
    logic [15:0]        r_cool, n_cool;
    logic               r_wait, n_wait;
    logic               r_armed, n_armed;

    logic               lneg, rneg;
    logic signed [15:0] drv_l, drv_r;
    logic               reach_l, reach_r;
    logic               cd_active, detected, go;
    logic [19:0]        run_inc;

    assign lneg = (i_item.direction == ems_pkg::DIR_BACKWARD) ||
                  (i_item.direction == ems_pkg::DIR_LEFT);
    assign rneg = (i_item.direction == ems_pkg::DIR_BACKWARD) ||
                  (i_item.direction == ems_pkg::DIR_RIGHT);

    ems_trim u_trim_l (
        .i_mag   (i_item.speed),
        .i_neg   (lneg),
        .i_trim  (i_cfg.left_trim),
        .i_max   (i_cfg.max_speed),
        .o_drive (drv_l)
    );

    ems_trim u_trim_r (
        .i_mag   (i_item.speed),
        .i_neg   (rneg),
        .i_trim  (i_cfg.right_trim),
        .i_max   (i_cfg.max_speed),
        .o_drive (drv_r)
    );

    ems_delta u_delta_l (
        .i_cur     (i_item.left_count),
        .i_start   (r_start_l),
        .i_target  (r_target),
        .o_reached (reach_l)
    );

    ems_delta u_delta_r (
        .i_cur     (i_item.right_count),
        .i_start   (r_start_r),
        .i_target  (r_target),
        .o_reached (reach_r)
    );

    assign cd_active = r_cool != 16'd0;
    assign detected  = ((i_cfg.obstacle_mode == ems_pkg::OBS_STOP) ||
                        (i_cfg.obstacle_mode == ems_pkg::OBS_PAUSE)) &&
                       (i_item.obstacle_dist != 12'd0) &&
                       (i_item.obstacle_dist <= i_cfg.obstacle_threshold);
    assign run_inc   = (r_run != ems_pkg::RUN_MAX) ? r_run + 20'd1 : r_run;

    always_comb begin
        n_active  = r_active;
        n_start_r = r_start_r;
        n_start_l = r_start_l;
        n_target  = r_target;
        n_run     = r_run;
        n_cmd_l   = r_cmd_l;
        n_cmd_r   = r_cmd_r;
        n_pause   = r_pause;
        n_cool    = r_cool;
        n_wait    = r_wait;
        n_armed   = r_armed;
        o_res     = '0;
        go        = 1'b0;

        if (i_item.cmd == ems_pkg::CMD_START) begin
            // Replace any running move; cooldown and arming carry over
            n_active  = 1'b1;
            n_start_r = i_item.right_count;
            n_start_l = i_item.left_count;
            n_target  = i_item.target_counts;
            n_run     = '0;
            n_pause   = '0;
            n_wait    = 1'b0;
            n_cmd_l   = drv_l;
            n_cmd_r   = drv_r;
            o_res.left_drive  = drv_l;
            o_res.right_drive = drv_r;
            o_res.moving      = 1'b1;
        end else begin
            if (cd_active) begin
                n_cool = r_cool - 16'd1;
            end
            if (r_active) begin
                if (r_pause != 16'd0) begin
                    // Timed pause running: load cooldown as the last tick ends
                    n_pause = r_pause - 16'd1;
                    if (r_pause == 16'd1) begin
                        n_cool = i_cfg.cooldown_ms;
                    end
                    o_res.moving = 1'b1;
                    o_res.paused = 1'b1;
                end else begin
                    go = 1'b1;
                    if (r_wait) begin
                        if (detected) begin
                            go = 1'b0;
                        end else begin
                            n_wait = 1'b0;
                        end
                    end else if (!detected) begin
                        n_armed = 1'b1;
                    end else if (i_cfg.obstacle_mode == ems_pkg::OBS_STOP) begin
                        n_wait = 1'b1;
                        go     = 1'b0;
                    end else if (!cd_active && r_armed) begin
                        n_armed = 1'b0;
                        if (i_cfg.pause_ms != 16'd0) begin
                            n_pause = i_cfg.pause_ms - 16'd1;
                            if (i_cfg.pause_ms == 16'd1) begin
                                n_cool = i_cfg.cooldown_ms;
                            end
                            go = 1'b0;
                        end else begin
                            n_cool = i_cfg.cooldown_ms;
                        end
                    end

                    if (!go) begin
                        o_res.moving = 1'b1;
                        o_res.paused = 1'b1;
                    end else begin
                        n_run = run_inc;
                        if (reach_l && reach_r) begin
                            n_active       = 1'b0;
                            o_res.done_res = 1'b1;
                        end else if ((i_cfg.timeout_ms != 20'd0) &&
                                     (run_inc >= i_cfg.timeout_ms)) begin
                            n_active        = 1'b0;
                            o_res.timed_out = 1'b1;
                        end else begin
                            o_res.left_drive  = r_cmd_l;
                            o_res.right_drive = r_cmd_r;
                            o_res.moving      = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_run    <= '0;
            r_pause  <= '0;
            r_cool   <= '0;
            r_wait   <= 1'b0;
            r_armed  <= 1'b1;
        end else if (i_obs_wr) begin
            // Obstacle settings changed: drop cooldown and re-arm
            r_cool  <= '0;
            r_armed <= 1'b1;
        end else if (i_step) begin
            r_active <= n_active;
            r_run    <= n_run;
            r_pause  <= n_pause;
            r_cool   <= n_cool;
            r_wait   <= n_wait;
            r_armed  <= n_armed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_start_r <= n_start_r;
            r_start_l <= n_start_l;
            r_target  <= n_target;
            r_cmd_l   <= n_cmd_l;
            r_cmd_r   <= n_cmd_r;
        end
    end
endmodule

[sv/ems_checker.sv]
// ----------------------------------------------------------------------------
// Move sequencer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ems_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_left_drive,
    input logic signed [15:0] i_right_drive,
    input logic               i_moving,
    input logic               i_paused,
    input logic               i_done_res,
    input logic               i_timed_out
);
    // Hold a stalled result unchanged
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable(i_left_drive) && $stable(i_right_drive) &&
            $stable(i_moving) && $stable(i_paused) &&
            $stable(i_done_res) && $stable(i_timed_out))
        else $error("stalled result changed");

    // A move ends one way only, and an ending result is not moving
    a_one_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_done_res || i_timed_out) |->
            !(i_done_res && i_timed_out) && !i_moving && !i_paused)
        else $error("inconsistent move end flags");

    // Paused results keep the move alive with the wheels stopped
    a_paused_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_paused |->
            i_moving && (i_left_drive == 16'sd0) && (i_right_drive == 16'sd0))
        else $error("paused result with nonzero drive");

    // No drive without a move in progress
    a_idle_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_moving |->
            (i_left_drive == 16'sd0) && (i_right_drive == 16'sd0))
        else $error("drive while not moving");
endmodule

bind encoder_move_sequencer ems_checker u_ems_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_left_drive  (o_res.left_drive),
    .i_right_drive (o_res.right_drive),
    .i_moving      (o_res.moving),
    .i_paused      (o_res.paused),
    .i_done_res    (o_res.done_res),
    .i_timed_out   (o_res.timed_out)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Encoder move sequencer testbench
// Sends start and tick transactions under random pacing and result-side
// stalls, keeps a cycle-free model of the move sequencing (trim, obstacle
// stop, timed pause with cooldown, target and timeout) and compares every
// result transaction against it, field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASES       = 14;
    localparam int MAX_SHOWN    = 10;
    // The fourth obstacle mode code has no name in the package; it acts as ignore.
    localparam logic [1:0] OBS_UNUSED = 2'd3;

    typedef logic [ems_pkg::CFG_DATA_W-1:0] t_cfg_data;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ems_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [ems_pkg::CFG_DATA_W-1:0] cfg_data;

    ems_in_if  in_ch ();
    ems_out_if res_ch ();

    encoder_move_sequencer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Register mirror, starting from the reset values
    // ------------------------------------------------------------------------
    logic [15:0] trim_l    = ems_pkg::RST_LEFT_TRIM;
    logic [15:0] trim_r    = ems_pkg::RST_RIGHT_TRIM;
    logic [14:0] max_spd   = ems_pkg::RST_MAX_SPEED;
    logic [19:0] tmo       = ems_pkg::RST_TIMEOUT_MS;
    logic [1:0]  obs_mode  = ems_pkg::RST_OBS_MODE;
    logic [11:0] obs_thr   = ems_pkg::RST_OBS_THR;
    logic [15:0] pause_len = ems_pkg::RST_PAUSE_MS;
    logic [15:0] cool_len  = ems_pkg::RST_COOLDOWN_MS;

    // Move state of the model
    logic        move_on       = 1'b0;
    logic [31:0] org_right     = '0;
    logic [31:0] org_left      = '0;
    logic [23:0] goal          = '0;
    logic [19:0] ticks_run     = '0;
    logic [15:0] drv_left_cmd  = '0;
    logic [15:0] drv_right_cmd = '0;
    logic [15:0] pause_left    = '0;
    logic [15:0] cool_left     = '0;
    logic        hold_clear    = 1'b0;
    logic        pause_armed   = 1'b1;

    // Results owed by the block, oldest first
    ems_pkg::t_res drive_results_q[$];

    int burst_left   = 0;
    int sent_items   = 0;
    int start_items  = 0;
    int tick_items   = 0;
    int done_moves   = 0;
    int timed_moves  = 0;
    int held_ticks   = 0;
    int checked      = 0;
    int bad_count    = 0;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Scale a magnitude by a Q2.14 gain, round half up, clamp, then sign it.
    function automatic logic [15:0] trim_drive(input logic [14:0] mag, input logic neg,
                                               input logic [15:0] gain);
        logic [31:0] p;
        p = ({17'd0, mag} * {16'd0, gain} + ems_pkg::TRIM_ROUND) >> ems_pkg::TRIM_SHIFT;
        if (p > {17'd0, max_spd}) p = {17'd0, max_spd};
        return neg ? -p[15:0] : p[15:0];
    endfunction

    // Distance travelled by one wheel: wrapped difference, magnitude as unsigned.
    function automatic logic [31:0] travel(input logic [31:0] now_cnt,
                                           input logic [31:0] from_cnt);
        logic [31:0] d;
        d = now_cnt - from_cnt;
        return d[31] ? -d : d;
    endfunction

    // Apply one transaction to the model and return the result it owes.
    function automatic ems_pkg::t_res advance_move(input ems_pkg::t_item it);
        ems_pkg::t_res r;
        ems_pkg::t_res halted;
        logic cd_was;
        logic seen;
        logic lneg;
        logic rneg;
        r = '0;
        halted = '0;
        halted.moving = 1'b1;
        halted.paused = 1'b1;

        if (it.cmd == ems_pkg::CMD_START) begin
            lneg = (it.direction == ems_pkg::DIR_BACKWARD) ||
                   (it.direction == ems_pkg::DIR_LEFT);
            rneg = (it.direction == ems_pkg::DIR_BACKWARD) ||
                   (it.direction == ems_pkg::DIR_RIGHT);
            move_on    = 1'b1;
            org_right  = it.right_count;
            org_left   = it.left_count;
            goal       = it.target_counts;
            ticks_run  = '0;
            pause_left = '0;
            hold_clear = 1'b0;
            drv_left_cmd  = trim_drive(it.speed, lneg, trim_l);
            drv_right_cmd = trim_drive(it.speed, rneg, trim_r);
            r.left_drive  = drv_left_cmd;
            r.right_drive = drv_right_cmd;
            r.moving      = 1'b1;
            return r;
        end

        // Cooldown runs on every tick, with or without a move.
        cd_was = (cool_left != 16'd0);
        if (cd_was) cool_left = cool_left - 16'd1;
        if (!move_on) return r;

        seen = ((obs_mode == ems_pkg::OBS_STOP) || (obs_mode == ems_pkg::OBS_PAUSE)) &&
               (it.obstacle_dist != 12'd0) && (it.obstacle_dist <= obs_thr);

        if (pause_left != 16'd0) begin
            pause_left = pause_left - 16'd1;
            if (pause_left == 16'd0) cool_left = cool_len;
            return halted;
        end

        if (hold_clear) begin
            if (seen) return halted;
            hold_clear = 1'b0;
        end else if (!seen) begin
            pause_armed = 1'b1;
        end else if (obs_mode == ems_pkg::OBS_STOP) begin
            hold_clear = 1'b1;
            return halted;
        end else if (!cd_was && pause_armed) begin
            pause_armed = 1'b0;
            if (pause_len != 16'd0) begin
                pause_left = pause_len - 16'd1;
                if (pause_left == 16'd0) cool_left = cool_len;
                return halted;
            end
            cool_left = cool_len;
        end

        if (ticks_run != ems_pkg::RUN_MAX) ticks_run = ticks_run + 20'd1;

        if (travel(it.right_count, org_right) >= {8'd0, goal} &&
            travel(it.left_count, org_left) >= {8'd0, goal}) begin
            move_on = 1'b0;
            r.done_res = 1'b1;
            return r;
        end
        if (tmo != 20'd0 && ticks_run >= tmo) begin
            move_on = 1'b0;
            r.timed_out = 1'b1;
            return r;
        end
        r.left_drive  = drv_left_cmd;
        r.right_drive = drv_right_cmd;
        r.moving      = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Transaction builders
    // ------------------------------------------------------------------------
    function automatic ems_pkg::t_item start_cmd(input logic [1:0] dir,
                                                 input logic [14:0] spd,
                                                 input logic [23:0] target,
                                                 input logic [31:0] rc,
                                                 input logic [31:0] lc,
                                                 input logic [11:0] obs_d);
        ems_pkg::t_item it;
        it = '0;
        it.cmd           = ems_pkg::CMD_START;
        it.direction     = dir;
        it.speed         = spd;
        it.target_counts = target;
        it.right_count   = rc;
        it.left_count    = lc;
        it.obstacle_dist = obs_d;
        return it;
    endfunction

    function automatic ems_pkg::t_item tick_cmd(input logic [31:0] rc,
                                                input logic [31:0] lc,
                                                input logic [11:0] obs_d);
        ems_pkg::t_item it;
        it = '0;
        it.cmd           = ems_pkg::CMD_TICK;
        it.right_count   = rc;
        it.left_count    = lc;
        it.obstacle_dist = obs_d;
        return it;
    endfunction

    // Extremes one time in four, otherwise a value in the working range.
    function automatic t_cfg_data pick_value(input int unsigned lo,
                                             input int unsigned hi,
                                             input int unsigned typ_lo,
                                             input int unsigned typ_hi);
        case ($urandom_range(0, 7))
            0:       return t_cfg_data'(lo);
            1:       return t_cfg_data'(hi);
            default: return t_cfg_data'($urandom_range(typ_lo, typ_hi));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // Send one transaction. Valid stays high on return so back-to-back
    // transactions need no drop; gaps come from the burst pacing only.
    task automatic send_item(input ems_pkg::t_item it);
        ems_pkg::t_res r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= it.cmd;
        in_ch.direction     <= it.direction;
        in_ch.speed         <= it.speed;
        in_ch.target_counts <= it.target_counts;
        in_ch.right_count   <= it.right_count;
        in_ch.left_count    <= it.left_count;
        in_ch.obstacle_dist <= it.obstacle_dist;
        do @(posedge clk); while (!in_ch.ready);

        r = advance_move(it);
        drive_results_q.push_back(r);
        sent_items++;
        if (it.cmd == ems_pkg::CMD_START) start_items++;
        else tick_items++;
        done_moves  += int'(r.done_res);
        timed_moves += int'(r.timed_out);
        held_ticks  += int'(r.paused);
    endtask

    // Drop valid and hold until every owed result is back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (drive_results_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register and mirror it; obstacle registers also reset the pause logic.
    task automatic set_register(input logic [ems_pkg::CFG_IDX_W-1:0] idx,
                                input logic [ems_pkg::CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            ems_pkg::CFG_LEFT_TRIM:     trim_l    = value[15:0];
            ems_pkg::CFG_RIGHT_TRIM:    trim_r    = value[15:0];
            ems_pkg::CFG_MAX_SPEED:     max_spd   = value[14:0];
            ems_pkg::CFG_TIMEOUT_MS:    tmo       = value[19:0];
            ems_pkg::CFG_OBSTACLE_MODE: obs_mode  = value[1:0];
            ems_pkg::CFG_OBSTACLE_THR:  obs_thr   = value[11:0];
            ems_pkg::CFG_PAUSE_MS:      pause_len = value[15:0];
            ems_pkg::CFG_COOLDOWN_MS:   cool_len  = value[15:0];
            default: ;
        endcase
        if (idx >= ems_pkg::CFG_OBSTACLE_MODE) begin
            cool_left   = '0;
            pause_armed = 1'b1;
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Idle tick, every direction, zero target, move replacement, count wrap.
    task automatic test_start_and_finish();
        send_item(tick_cmd(32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
        send_item(start_cmd(ems_pkg::DIR_FORWARD, 15'h7FFF, 24'd0, 32'd0, 32'd0, 12'hFFF));
        send_item(tick_cmd(32'd0, 32'd0, 12'd0));
        send_item(start_cmd(ems_pkg::DIR_BACKWARD, 15'h4000, 24'hFFFFFF, 32'h7FFF_FFF0,
                            32'd0, 12'd0));
        // right wraps through the sign boundary, left travels exactly 2^31
        send_item(tick_cmd(32'h8000_0010, 32'h8000_0000, 12'd1));
        send_item(start_cmd(ems_pkg::DIR_RIGHT, 15'd1, 24'd5, 32'd100, 32'd100, 12'd0));
        send_item(tick_cmd(32'd97, 32'd103, 12'd0));
        send_item(tick_cmd(32'd95, 32'd105, 12'd0));
        send_item(start_cmd(ems_pkg::DIR_LEFT, 15'd100, 24'd10, 32'hFFFF_FFFB, 32'd5,
                            12'd0));
        send_item(tick_cmd(32'd5, 32'hFFFF_FFFB, 12'd0));
    endtask

    // Trim and speed limits, immediate timeout, target beating timeout.
    task automatic test_register_limits();
        settle();
        set_register(ems_pkg::CFG_LEFT_TRIM, 20'd0);
        set_register(ems_pkg::CFG_RIGHT_TRIM, 20'hFFFF);
        set_register(ems_pkg::CFG_MAX_SPEED, 20'd1000);
        send_item(start_cmd(ems_pkg::DIR_FORWARD, 15'h7FFF, 24'd50, 32'd0, 32'd0, 12'd0));
        settle();
        set_register(ems_pkg::CFG_MAX_SPEED, 20'd0);
        send_item(start_cmd(ems_pkg::DIR_LEFT, 15'h7FFF, 24'd50, 32'd0, 32'd0, 12'd0));
        settle();
        set_register(ems_pkg::CFG_MAX_SPEED, 20'h7FFF);
        set_register(ems_pkg::CFG_TIMEOUT_MS, 20'd1);
        send_item(start_cmd(ems_pkg::DIR_FORWARD, 15'd100, 24'd50, 32'd0, 32'd0, 12'd0));
        send_item(tick_cmd(32'd0, 32'd0, 12'd0));
        send_item(start_cmd(ems_pkg::DIR_FORWARD, 15'd100, 24'd0, 32'd0, 32'd0, 12'd0));
        send_item(tick_cmd(32'd0, 32'd0, 12'd0));
        settle();
        set_register(ems_pkg::CFG_TIMEOUT_MS, 20'hFFFFF);
        set_register(ems_pkg::CFG_LEFT_TRIM, 20'hFFFF);
        set_register(ems_pkg::CFG_RIGHT_TRIM, {4'd0, ems_pkg::RST_RIGHT_TRIM});
        send_item(start_cmd(ems_pkg::DIR_BACKWARD, 15'd12345, 24'd1000, 32'd0, 32'd0,
                            12'd0));
        send_item(tick_cmd(32'd0, 32'd0, 12'd0));
    endtask

    // Stop until clear, timed pause, zero pause, unused mode, long pause cut
    // short by a new start, long cooldown masking a second obstacle.
    task automatic test_obstacles();
        settle();
        set_register(ems_pkg::CFG_OBSTACLE_MODE, {18'd0, ems_pkg::OBS_STOP});
        set_register(ems_pkg::CFG_OBSTACLE_THR, 20'hFFF);
        send_item(start_cmd(ems_pkg::DIR_FORWARD, 15'd20000, 24'd1000, 32'd0, 32'd0,
                            12'hFFF));
        send_item(tick_cmd(32'd0, 32'd0, 12'hFFF));
        send_item(tick_cmd(32'd0, 32'd0, 12'd1));
        send_item(tick_cmd(32'd0, 32'd0, 12'd0));

        settle();
        set_register(ems_pkg::CFG_OBSTACLE_MODE, {18'd0, ems_pkg::OBS_PAUSE});
        set_register(ems_pkg::CFG_OBSTACLE_THR, 20'd100);
        set_register(ems_pkg::CFG_PAUSE_MS, 20'd2);
        set_register(ems_pkg::CFG_COOLDOWN_MS, 20'd3);
        send_item(tick_cmd(32'd0, 32'd0, 12'd50));
        send_item(tick_cmd(32'd0, 32'd0, 12'd50));
        send_item(tick_cmd(32'd0, 32'd0, 12'd50));
        send_item(tick_cmd(32'd0, 32'd0, 12'd101));

        settle();
        set_register(ems_pkg::CFG_PAUSE_MS, 20'd0);
        set_register(ems_pkg::CFG_COOLDOWN_MS, 20'd1);
        send_item(tick_cmd(32'd0, 32'd0, 12'd100));
        settle();
        set_register(ems_pkg::CFG_OBSTACLE_MODE, {18'd0, OBS_UNUSED});
        send_item(tick_cmd(32'd0, 32'd0, 12'd5));

        settle();
        set_register(ems_pkg::CFG_OBSTACLE_MODE, {18'd0, ems_pkg::OBS_PAUSE});
        set_register(ems_pkg::CFG_PAUSE_MS, 20'hFFFF);
        set_register(ems_pkg::CFG_COOLDOWN_MS, 20'hFFFF);
        send_item(tick_cmd(32'd0, 32'd0, 12'd5));
        send_item(tick_cmd(32'd0, 32'd0, 12'd5));
        send_item(start_cmd(ems_pkg::DIR_RIGHT, 15'd300, 24'd1000, 32'd0, 32'd0, 12'd5));
        send_item(tick_cmd(32'd0, 32'd0, 12'd5));
        send_item(tick_cmd(32'd0, 32'd0, 12'd0));
        settle();
        set_register(ems_pkg::CFG_PAUSE_MS, 20'd1);
        send_item(tick_cmd(32'd0, 32'd0, 12'd5));
        send_item(tick_cmd(32'd0, 32'd0, 12'd5));
    endtask

    // ------------------------------------------------------------------------
    // Random test
    // ------------------------------------------------------------------------

    // One plausible move: a start, then ticks whose counts advance the way the
    // wheels turn, with obstacle bursts, until the move ends or is cut short.
    task automatic run_move();
        logic [1:0]  dir;
        logic [23:0] target;
        logic [31:0] rpos;
        logic [31:0] lpos;
        logic [11:0] obs_d;
        logic        lneg;
        logic        rneg;
        int          cap;
        int          obs_run;
        int          n;
        dir  = 2'($urandom_range(0, 3));
        lneg = (dir == ems_pkg::DIR_BACKWARD) || (dir == ems_pkg::DIR_LEFT);
        rneg = (dir == ems_pkg::DIR_BACKWARD) || (dir == ems_pkg::DIR_RIGHT);
        rpos = $urandom;
        lpos = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            rpos = 32'h7FFF_FFF8;
            lpos = 32'hFFFF_FFF8;
        end
        case ($urandom_range(0, 19))
            0:       target = '0;
            1:       target = 24'($urandom);
            default: target = 24'($urandom_range(1, 150));
        endcase
        send_item(start_cmd(dir, 15'($urandom_range(0, 32767)), target, rpos, lpos,
                            12'($urandom)));

        cap = $urandom_range(5, 80);
        obs_run = 0;
        for (n = 0; n < cap && move_on; n++) begin
            rpos = rneg ? rpos - $urandom_range(0, 12) : rpos + $urandom_range(0, 12);
            lpos = lneg ? lpos - $urandom_range(0, 12) : lpos + $urandom_range(0, 12);
            if (obs_run == 0 && $urandom_range(0, 11) == 0) obs_run = $urandom_range(1, 8);
            if (obs_run > 0) begin
                obs_run--;
                obs_d = (obs_thr == 12'd0) ? 12'd0 : 12'($urandom_range(1, obs_thr));
            end else if (obs_thr == 12'hFFF || $urandom_range(0, 3) == 0) begin
                obs_d = 12'd0;
            end else begin
                obs_d = 12'($urandom_range(obs_thr + 1, 4095));
            end
            send_item(tick_cmd(rpos, lpos, obs_d));
        end

        // A few idle ticks keep the cooldown running down between moves.
        if (!move_on) begin
            repeat ($urandom_range(0, 2)) send_item(tick_cmd($urandom, $urandom,
                                                             12'($urandom)));
        end
    endtask

    // Phases of random settings, each followed by a full drain before the
    // next set of register writes.
    task automatic test_random_moves();
        int phase;
        int budget_end;
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            set_register(ems_pkg::CFG_LEFT_TRIM,     pick_value(0, 65535, 8192, 32768));
            set_register(ems_pkg::CFG_RIGHT_TRIM,    pick_value(0, 65535, 8192, 32768));
            set_register(ems_pkg::CFG_MAX_SPEED,     pick_value(0, 32767, 1000, 32767));
            set_register(ems_pkg::CFG_TIMEOUT_MS,    pick_value(0, 1048575, 3, 80));
            set_register(ems_pkg::CFG_OBSTACLE_MODE,
                         pick_value(32'(ems_pkg::OBS_IGNORE), 32'(OBS_UNUSED),
                                    32'(ems_pkg::OBS_STOP), 32'(ems_pkg::OBS_PAUSE)));
            set_register(ems_pkg::CFG_OBSTACLE_THR,  pick_value(0, 4095, 20, 1000));
            set_register(ems_pkg::CFG_PAUSE_MS,      pick_value(0, 1, 0, 6));
            set_register(ems_pkg::CFG_COOLDOWN_MS,   pick_value(0, 1, 0, 12));

            budget_end = sent_items + RANDOM_ITEMS / PHASES;
            while (sent_items < budget_end) begin
                case ($urandom_range(0, 19))
                    0: send_item(start_cmd(2'($urandom), 15'($urandom), 24'($urandom),
                                           $urandom, $urandom, 12'($urandom)));
                    1: send_item(tick_cmd($urandom, $urandom, 12'($urandom)));
                    default: run_move();
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------------

    // Switch stall style at random: none, light, heavy or periodic.
    initial begin : result_stalls
        int unsigned cyc;
        int          stall_mode;
        res_ch.ready = 1'b0;
        cyc = 0;
        stall_mode = 0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       res_ch.ready <= ($urandom_range(0, 2) == 0);
                default: res_ch.ready <= (cyc % 7 >= 3);
            endcase
        end
    end

    // Compare each accepted result with the oldest owed one.
    always @(posedge clk) begin : check_results
        ems_pkg::t_res got;
        ems_pkg::t_res want;
        logic wrong;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.left_drive  = res_ch.left_drive;
            got.right_drive = res_ch.right_drive;
            got.moving      = res_ch.moving;
            got.paused      = res_ch.paused;
            got.done_res    = res_ch.done_res;
            got.timed_out   = res_ch.timed_out;
            if (drive_results_q.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_SHOWN)
                    $display("%0t: result with none owed: L=%0d R=%0d mv=%b pa=%b dn=%b to=%b",
                             $realtime, got.left_drive, got.right_drive, got.moving,
                             got.paused, got.done_res, got.timed_out);
            end else begin
                want = drive_results_q.pop_front();
                checked++;
                wrong = (got.left_drive !== want.left_drive) ||
                        (got.right_drive !== want.right_drive) ||
                        (got.moving !== want.moving) ||
                        (got.paused !== want.paused) ||
                        (got.done_res !== want.done_res) ||
                        (got.timed_out !== want.timed_out);
                if (wrong) begin
                    bad_count++;
                    if (bad_count <= MAX_SHOWN)
                        $display({"%0t: result %0d got L=%0d R=%0d mv=%b pa=%b dn=%b to=%b,",
                                  " want L=%0d R=%0d mv=%b pa=%b dn=%b to=%b"},
                                 $realtime, checked, got.left_drive, got.right_drive,
                                 got.moving, got.paused, got.done_res, got.timed_out,
                                 want.left_drive, want.right_drive, want.moving,
                                 want.paused, want.done_res, want.timed_out);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------------
    initial begin
        in_ch.valid         = 1'b0;
        in_ch.cmd           = ems_pkg::CMD_TICK;
        in_ch.direction     = ems_pkg::DIR_FORWARD;
        in_ch.speed         = '0;
        in_ch.target_counts = '0;
        in_ch.right_count   = '0;
        in_ch.left_count    = '0;
        in_ch.obstacle_dist = '0;
        cfg_we              = 1'b0;
        cfg_idx             = ems_pkg::CFG_LEFT_TRIM;
        cfg_data            = '0;
        rst_n               = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_start_and_finish();
        test_register_limits();
        test_obstacles();
        test_random_moves();
        settle();

        $display("covered %0d transactions (%0d starts, %0d ticks) over %0d setting phases",
                 sent_items, start_items, tick_items, PHASES);
        $display("moves reaching target %0d, timed out %0d, ticks held for obstacles %0d",
                 done_moves, timed_moves, held_ticks);
        if (bad_count == 0) begin
            $display("encoder_move_sequencer: match");
        end else begin
            $display("encoder_move_sequencer: mismatch");
        end
        $finish;
    end

    // Stop a hung run; the slowest correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("run stopped at its time limit, %0d results still owed",
                 drive_results_q.size());
        $display("encoder_move_sequencer: mismatch");
        $finish;
    end

endmodule
